### sv/ltiyp_pkg.sv
// Types and constants shared by the serial command line parser.
`timescale 1ns / 1ps

package ltiyp_pkg;

   typedef enum logic [2:0] {
      KIND_EMPTY = 3'd0,
      KIND_INT   = 3'd1,
      KIND_YES   = 3'd2,
      KIND_NO    = 3'd3,
      KIND_ERROR = 3'd4
   } line_kind_type;

   typedef enum logic [4:0] {
      PH_SKIP   = 5'b00001,
      PH_SIGNED = 5'b00010,
      PH_DIGITS = 5'b00100,
      PH_DONE   = 5'b01000,
      PH_FAIL   = 5'b10000
   } scan_phase_type;

   typedef enum logic {
      CSR_PARSE_MODE    = 1'b0,
      CSR_EMPTY_ALLOWED = 1'b1
   } csr_index_type;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

endpackage

### sv/line_token_int_yesno_parser.sv
// Serial command line parser: integer or yes/no word per terminated line.
// A line terminator is held in the input register, and then its result in the result register.
// Throughput: one byte per cycle; the input register and the result register decouple
// the two channels, and a byte stalls only while an untaken result blocks a terminator.
// Reset: synchronous active-high reset clears the valid flags of both registers, the
// line state and the configuration (integer mode, empty lines reported as errors).
`timescale 1ns / 1ps

module line_token_int_yesno_parser #(
   parameter int MAX_LINE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_line_kind,
   output logic signed [31:0] rsp_int_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   localparam int LenWidth = $clog2(MAX_LINE + 1);
   localparam logic [LenWidth-1:0] LenMax = LenWidth'(MAX_LINE);

   logic                parse_mode_ff, empty_allowed_ff;
   logic                byte_valid_ff;
   logic [7:0]          byte_ff;
   logic [LenWidth-1:0] line_length_ff, line_length_in;
   ltiyp_pkg::scan_phase_type scan_phase_ff, scan_phase_in;
   logic [31:0]         accumulator_ff, accumulator_in;
   logic                negative_ff, negative_in;
   logic                digit_seen_ff, digit_seen_in;
   logic [7:0]          prefix_ff [3];
   logic [7:0]          prefix_in [3];
   logic [2:0]          text_length_ff, text_length_in;
   logic                nul_seen_ff, nul_seen_in;
   logic                rsp_valid_ff;
   logic [2:0]          kind_ff;
   logic [31:0]         value_ff;
   ltiyp_pkg::line_kind_type kind_in;
   logic [31:0]         value_in;

   logic        is_term, advance, is_digit, yes_match, no_match;
   logic [35:0] times_ten;
   logic [3:0]  digit_val;

   assign is_term   = (byte_ff == ltiyp_pkg::CHAR_NL) || (byte_ff == ltiyp_pkg::CHAR_SEMI);
   assign advance   = byte_valid_ff && (!is_term || !rsp_valid_ff || rsp_ready);
   assign req_ready = !byte_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign is_digit  = (byte_ff >= ltiyp_pkg::CHAR_ZERO) && (byte_ff <= ltiyp_pkg::CHAR_NINE);
   assign digit_val = 4'(byte_ff - ltiyp_pkg::CHAR_ZERO);
   assign times_ten = {1'b0, accumulator_ff, 3'b000} + {3'b000, accumulator_ff, 1'b0}
                    + {32'd0, digit_val};

   assign yes_match = ((text_length_ff == 3'd3) &&
                       ((prefix_ff[0] == "Y" && prefix_ff[1] == "E" && prefix_ff[2] == "S") ||
                        (prefix_ff[0] == "Y" && prefix_ff[1] == "e" && prefix_ff[2] == "s") ||
                        (prefix_ff[0] == "y" && prefix_ff[1] == "e" && prefix_ff[2] == "s"))) ||
                      ((text_length_ff == 3'd1) && (prefix_ff[0] == "1"));
   assign no_match  = ((text_length_ff == 3'd2) &&
                       ((prefix_ff[0] == "N" && prefix_ff[1] == "O") ||
                        (prefix_ff[0] == "N" && prefix_ff[1] == "o") ||
                        (prefix_ff[0] == "n" && prefix_ff[1] == "o"))) ||
                      ((text_length_ff == 3'd1) && (prefix_ff[0] == "0"));

   always_comb begin
      line_length_in = line_length_ff;
      scan_phase_in  = scan_phase_ff;
      accumulator_in = accumulator_ff;
      negative_in    = negative_ff;
      digit_seen_in  = digit_seen_ff;
      prefix_in      = prefix_ff;
      text_length_in = text_length_ff;
      nul_seen_in    = nul_seen_ff;
      kind_in        = ltiyp_pkg::KIND_ERROR;
      value_in       = 32'd0;

      if (is_term) begin
         line_length_in = '0;
         scan_phase_in  = ltiyp_pkg::PH_SKIP;
         accumulator_in = 32'd0;
         negative_in    = 1'b0;
         digit_seen_in  = 1'b0;
         prefix_in      = '{8'd0, 8'd0, 8'd0};
         text_length_in = 3'd0;
         nul_seen_in    = 1'b0;
         if (line_length_ff == '0) begin
            kind_in = empty_allowed_ff ? ltiyp_pkg::KIND_EMPTY : ltiyp_pkg::KIND_ERROR;
         end else if (line_length_ff >= LenMax) begin
            kind_in = ltiyp_pkg::KIND_ERROR;
         end else if (!parse_mode_ff) begin
            if (digit_seen_ff) begin
               kind_in = ltiyp_pkg::KIND_INT;
               if (negative_ff) begin
                  value_in = 32'd0 - accumulator_ff;
               end else begin
                  value_in = (accumulator_ff >= ltiyp_pkg::MAG_LIMIT) ?
                             ltiyp_pkg::POS_MAX : accumulator_ff;
               end
            end
         end else if (yes_match) begin
            kind_in = ltiyp_pkg::KIND_YES;
         end else if (no_match) begin
            kind_in = ltiyp_pkg::KIND_NO;
         end
      end else begin
         if (line_length_ff < LenMax) begin
            line_length_in = line_length_ff + 1'b1;
         end
         if (!nul_seen_ff) begin
            if (byte_ff == ltiyp_pkg::CHAR_NUL) begin
               nul_seen_in = 1'b1;
            end else begin
               if (text_length_ff < 3'd3) begin
                  prefix_in[text_length_ff[1:0]] = byte_ff;
               end
               if (text_length_ff < 3'd4) begin
                  text_length_in = text_length_ff + 3'd1;
               end
               unique case (scan_phase_ff)
                  ltiyp_pkg::PH_SKIP: begin
                     if (ltiyp_pkg::is_blank(byte_ff)) begin
                        scan_phase_in = ltiyp_pkg::PH_SKIP;
                     end else if (byte_ff == ltiyp_pkg::CHAR_PLUS ||
                                  byte_ff == ltiyp_pkg::CHAR_MINUS) begin
                        negative_in   = (byte_ff == ltiyp_pkg::CHAR_MINUS);
                        scan_phase_in = ltiyp_pkg::PH_SIGNED;
                     end else if (is_digit) begin
                        accumulator_in = {28'd0, digit_val};
                        digit_seen_in  = 1'b1;
                        scan_phase_in  = ltiyp_pkg::PH_DIGITS;
                     end else begin
                        scan_phase_in = ltiyp_pkg::PH_FAIL;
                     end
                  end
                  ltiyp_pkg::PH_SIGNED, ltiyp_pkg::PH_DIGITS: begin
                     if (is_digit) begin
                        accumulator_in = (times_ten > {4'd0, ltiyp_pkg::MAG_LIMIT}) ?
                                         ltiyp_pkg::MAG_LIMIT : times_ten[31:0];
                        digit_seen_in  = 1'b1;
                        scan_phase_in  = ltiyp_pkg::PH_DIGITS;
                     end else begin
                        scan_phase_in = (scan_phase_ff == ltiyp_pkg::PH_DIGITS) ?
                                        ltiyp_pkg::PH_DONE : ltiyp_pkg::PH_FAIL;
                     end
                  end
                  default: begin
                     scan_phase_in = scan_phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_mode_ff    <= 1'b0;
         empty_allowed_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ltiyp_pkg::CSR_PARSE_MODE:    parse_mode_ff    <= csr_wdata;
            ltiyp_pkg::CSR_EMPTY_ALLOWED: empty_allowed_ff <= csr_wdata;
            default: parse_mode_ff <= parse_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ready) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         scan_phase_ff  <= ltiyp_pkg::PH_SKIP;
         accumulator_ff <= 32'd0;
         negative_ff    <= 1'b0;
         digit_seen_ff  <= 1'b0;
         prefix_ff      <= '{8'd0, 8'd0, 8'd0};
         text_length_ff <= 3'd0;
         nul_seen_ff    <= 1'b0;
      end else if (advance) begin
         line_length_ff <= line_length_in;
         scan_phase_ff  <= scan_phase_in;
         accumulator_ff <= accumulator_in;
         negative_ff    <= negative_in;
         digit_seen_ff  <= digit_seen_in;
         prefix_ff      <= prefix_in;
         text_length_ff <= text_length_in;
         nul_seen_ff    <= nul_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && is_term) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_term) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_kind = kind_ff;
   assign rsp_int_value = value_ff;

endmodule

### sim/tb_line_token_int_yesno_parser.sv
// Self-checking testbench for the serial command line parser with a line predictor.
`timescale 1ns / 1ps

module tb_line_token_int_yesno_parser;

   localparam int LINE_LIMIT  = 1024;
   localparam int PHASE_BYTES = 150;
   localparam int HOLD_AT     = 40;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 4;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      ltiyp_pkg::line_kind_type kind;
      logic signed [31:0]       value;
   } line_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_line_kind;
   logic signed [31:0] rsp_int_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic               csr_wdata = 1'b0;

   logic [7:0]      tx_bytes[$];
   line_result_type line_results[$];

   int unsigned cycle_count = 0;
   int unsigned bytes_pushed = 0;
   int unsigned bytes_taken = 0;
   int unsigned results_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned rsp_taken = 0;
   logic        hold_done = 1'b0;

   logic                      cfg_mode = 1'b0;
   logic                      cfg_empty_ok = 1'b0;
   int unsigned               line_len = 0;
   ltiyp_pkg::scan_phase_type phase = ltiyp_pkg::PH_SKIP;
   logic [31:0]               magnitude = '0;
   logic                      minus = 1'b0;
   logic                      got_digit = 1'b0;
   logic [0:2][7:0]           head = '0;
   logic [2:0]                text_len = '0;
   logic                      nul_hit = 1'b0;

   line_token_int_yesno_parser #(
      .MAX_LINE(LINE_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_line_kind(rsp_line_kind),
      .rsp_int_value(rsp_int_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned pause_len();
      if (cycle_count[8:7] == 2'b00) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic logic is_whitespace(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

   task automatic clear_line();
      line_len = 0;
      phase = ltiyp_pkg::PH_SKIP;
      magnitude = '0;
      minus = 1'b0;
      got_digit = 1'b0;
      head = '0;
      text_len = '0;
      nul_hit = 1'b0;
   endtask

   task automatic scan_line_byte(input logic [7:0] c);
      logic            digit;
      logic [63:0]     wide;
      line_result_type res;
      digit = (c >= ltiyp_pkg::CHAR_ZERO) && (c <= ltiyp_pkg::CHAR_NINE);
      if (c != ltiyp_pkg::CHAR_NL && c != ltiyp_pkg::CHAR_SEMI) begin
         if (line_len < LINE_LIMIT) begin
            line_len++;
         end
         if (!nul_hit && c == ltiyp_pkg::CHAR_NUL) begin
            nul_hit = 1'b1;
         end else if (!nul_hit) begin
            if (text_len < 3) begin
               head[text_len[1:0]] = c;
            end
            if (text_len < 4) begin
               text_len++;
            end
            case (phase)
               ltiyp_pkg::PH_SKIP: begin
                  if (is_whitespace(c)) begin
                  end else if (c == ltiyp_pkg::CHAR_PLUS || c == ltiyp_pkg::CHAR_MINUS) begin
                     minus = (c == ltiyp_pkg::CHAR_MINUS);
                     phase = ltiyp_pkg::PH_SIGNED;
                  end else if (digit) begin
                     magnitude = {24'd0, 8'(c - ltiyp_pkg::CHAR_ZERO)};
                     got_digit = 1'b1;
                     phase = ltiyp_pkg::PH_DIGITS;
                  end else begin
                     phase = ltiyp_pkg::PH_FAIL;
                  end
               end
               ltiyp_pkg::PH_SIGNED, ltiyp_pkg::PH_DIGITS: begin
                  if (digit) begin
                     wide = {32'd0, magnitude} * 64'd10
                          + {56'd0, 8'(c - ltiyp_pkg::CHAR_ZERO)};
                     magnitude = (wide > {32'd0, ltiyp_pkg::MAG_LIMIT}) ?
                                 ltiyp_pkg::MAG_LIMIT : wide[31:0];
                     got_digit = 1'b1;
                     phase = ltiyp_pkg::PH_DIGITS;
                  end else begin
                     phase = (phase == ltiyp_pkg::PH_DIGITS) ?
                             ltiyp_pkg::PH_DONE : ltiyp_pkg::PH_FAIL;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         res.value = '0;
         if (line_len == 0) begin
            res.kind = cfg_empty_ok ? ltiyp_pkg::KIND_EMPTY : ltiyp_pkg::KIND_ERROR;
         end else if (line_len >= LINE_LIMIT) begin
            res.kind = ltiyp_pkg::KIND_ERROR;
         end else if (!cfg_mode) begin
            if (got_digit) begin
               res.kind = ltiyp_pkg::KIND_INT;
               res.value = minus ? -magnitude :
                           ((magnitude >= ltiyp_pkg::MAG_LIMIT) ?
                            ltiyp_pkg::POS_MAX : magnitude);
            end else begin
               res.kind = ltiyp_pkg::KIND_ERROR;
            end
         end else if ((text_len == 3 && (head == "YES" || head == "Yes" || head == "yes")) ||
                      (text_len == 1 && head[0] == "1")) begin
            res.kind = ltiyp_pkg::KIND_YES;
         end else if ((text_len == 2 && ({head[0], head[1]} == "NO" ||
                       {head[0], head[1]} == "No" || {head[0], head[1]} == "no")) ||
                      (text_len == 1 && head[0] == "0")) begin
            res.kind = ltiyp_pkg::KIND_NO;
         end else begin
            res.kind = ltiyp_pkg::KIND_ERROR;
         end
         line_results.push_back(res);
         clear_line();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (tx_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= tx_bytes.pop_front();
            send_gap <= pause_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      int unsigned wait_len;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
         rsp_taken <= 0;
         hold_done <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         wait_len = pause_len();
         if (!hold_done && rsp_taken == HOLD_AT) begin
            wait_len = LONG_HOLD;
            hold_done <= 1'b1;
         end
         rsp_taken <= rsp_taken + 1;
         recv_gap <= wait_len;
         rsp_ready <= (wait_len == 0);
      end else if (recv_gap != 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= (recv_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      line_result_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         clear_line();
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (line_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, kind %0d value %0d", $time, rsp_line_kind,
                        rsp_int_value);
            end else begin
               want = line_results.pop_front();
               if (rsp_line_kind !== want.kind || rsp_int_value !== want.value) begin
                  errors++;
                  $display("%0t: mismatch, expected kind %0d value %0d, got kind %0d value %0d",
                           $time, want.kind, want.value, rsp_line_kind, rsp_int_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            bytes_taken <= bytes_taken + 1;
            scan_line_byte(req_rx_byte);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      bytes_pushed++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == ltiyp_pkg::CHAR_NL || b == ltiyp_pkg::CHAR_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0D;
         3: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   function automatic logic [7:0] end_char();
      return $urandom_range(0, 1) ? ltiyp_pkg::CHAR_NL : ltiyp_pkg::CHAR_SEMI;
   endfunction

   function automatic logic [7:0] sign_char();
      return $urandom_range(0, 1) ? ltiyp_pkg::CHAR_MINUS : ltiyp_pkg::CHAR_PLUS;
   endfunction

   task automatic push_int_line();
      longint v;
      int     n;
      int     sel;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) push_byte(blank_char());
      sel = $urandom_range(0, 5);
      if (sel == 4) begin
         if ($urandom_range(0, 1)) begin
            push_byte(sign_char());
         end
         n = $urandom_range(1, 14);
         repeat (n) push_byte(8'(ltiyp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end else if (sel == 5) begin
         push_byte(sign_char());
         if ($urandom_range(0, 1)) begin
            push_byte(junk_byte());
         end
      end else begin
         case (sel)
            0: v = longint'($urandom_range(0, 999));
            1: v = longint'($signed($urandom));
            default: begin
               case ($urandom_range(0, 5))
                  0: v = 64'sd2147483647;
                  1: v = 64'sd2147483648;
                  2: v = -64'sd2147483648;
                  3: v = -64'sd2147483649;
                  4: v = 64'sd0;
                  default: v = 64'sd99999999999;
               endcase
            end
         endcase
         if (v >= 0 && $urandom_range(0, 3) == 0) begin
            push_byte(ltiyp_pkg::CHAR_PLUS);
         end
         push_text($sformatf("%0d", v));
      end
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(junk_byte());
      end
      push_byte(end_char());
   endtask

   task automatic push_word_line();
      string s;
      int    n;
      case ($urandom_range(0, 15))
         0: s = "YES";
         1: s = "Yes";
         2: s = "yes";
         3: s = "1";
         4: s = "NO";
         5: s = "No";
         6: s = "no";
         7: s = "0";
         8: s = "YE";
         9: s = "yess";
         10: s = "nO";
         11: s = "Y";
         12: s = "2";
         13: s = "00";
         14: s = "yES";
         default: s = "N0";
      endcase
      if ($urandom_range(0, 7) == 0) begin
         push_byte(blank_char());
      end
      push_text(s);
      case ($urandom_range(0, 5))
         0: begin
            push_byte(ltiyp_pkg::CHAR_NUL);
            n = $urandom_range(0, 3);
            repeat (n) push_byte(junk_byte());
         end
         1: push_byte(junk_byte());
         default: begin
         end
      endcase
      push_byte(end_char());
   endtask

   task automatic push_noise_line();
      int n;
      n = $urandom_range(0, 12);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      push_byte(end_char());
   endtask

   task automatic push_long_line(input string s, input int total, input logic with_nul);
      push_text(s);
      if (with_nul) begin
         push_byte(ltiyp_pkg::CHAR_NUL);
      end
      repeat (total - s.len() - with_nul) push_byte(junk_byte());
      push_byte(end_char());
   endtask

   task automatic run_random();
      int unsigned start;
      int          r;
      start = bytes_pushed;
      while (bytes_pushed - start < PHASE_BYTES) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            if (cfg_mode) begin
               push_word_line();
            end else begin
               push_int_line();
            end
         end else if (r == 6) begin
            if (cfg_mode) begin
               push_int_line();
            end else begin
               push_word_line();
            end
         end else if (r == 8) begin
            push_byte(end_char());
         end else begin
            push_noise_line();
         end
      end
   endtask

   task automatic settle();
      @(posedge clock);
      while (bytes_taken != bytes_pushed || line_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input ltiyp_pkg::csr_index_type idx, input logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_writes++;
      if (idx == ltiyp_pkg::CSR_PARSE_MODE) begin
         cfg_mode = val;
      end else begin
         cfg_empty_ok = val;
      end
   endtask

   task automatic apply_settings(input logic mode, input logic empty_ok);
      settle();
      write_csr(ltiyp_pkg::CSR_PARSE_MODE, mode);
      write_csr(ltiyp_pkg::CSR_EMPTY_ALLOWED, empty_ok);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_byte(ltiyp_pkg::CHAR_SEMI);
      push_text("\t-12x\n");
      push_text("+;");
      push_byte(8'hFF);
      push_byte(ltiyp_pkg::CHAR_NL);
      push_byte("7");
      push_byte(ltiyp_pkg::CHAR_NUL);
      push_text("9\n");
      // The open line "1" is terminated after the switch to yes/no mode.
      push_byte("1");
      apply_settings(1'b1, 1'b1);
      push_byte(ltiyp_pkg::CHAR_NL);
      push_byte(ltiyp_pkg::CHAR_NL);
      push_text("Yes;");
      push_text("no");
      push_byte(ltiyp_pkg::CHAR_NUL);
      push_byte(ltiyp_pkg::CHAR_SEMI);

      push_long_line("yes", LINE_LIMIT, 1'b1);

      apply_settings(1'b0, 1'b1);
      run_random();
      apply_settings(1'b1, 1'b0);
      run_random();
      apply_settings(1'b0, 1'b0);
      run_random();
      apply_settings(1'b1, 1'b1);
      run_random();
      settle();

      errors += line_results.size();
      $display("Covered %0d bytes, %0d line results and %0d register writes in four settings.",
               bytes_taken, results_seen, csr_writes);
      $display("Lines held integers, yes/no words, empty, NUL-cut, overlong and saturated values.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
